[rtl/pfp_pkg.sv]
// Package for the pressure frame parser: character codes, status codes,
// field phase codes, widths and small character-class functions.
// Depends on nothing; every other file of the parser uses it.
`timescale 1ns / 1ps
`default_nettype none

package pfp_pkg;

  localparam int MAX_PAYLOAD = 7;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int BYTE_W      = 8;
  localparam int VAL_W       = 10;
  localparam int STATUS_W    = 2;
  localparam int ACC_W       = 14;

  localparam logic [BYTE_W-1:0] CH_START = 8'h3B;
  localparam logic [BYTE_W-1:0] CH_END   = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SEP   = 8'h78;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

  localparam logic [VAL_W-1:0] VAL_MAX   = 10'd999;
  localparam logic [VAL_W-1:0] VAL_SAT   = 10'd1000;

  typedef enum logic [STATUS_W-1:0] {
    ST_VALID    = 2'd0,
    ST_BAD      = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

`default_nettype wire

[rtl/pfp_byte_if.sv]
// Valid/ready channel that carries one received character per word.
// Depends on pfp_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

interface pfp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [pfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[rtl/pfp_result_if.sv]
// Valid/ready channel that carries one parsed frame result per word.
// Depends on pfp_pkg for the status and value widths.
`timescale 1ns / 1ps
`default_nettype none

interface pfp_result_if;
  logic                         valid;
  logic                         ready;
  logic [pfp_pkg::STATUS_W-1:0] status;
  logic [pfp_pkg::VAL_W-1:0]    systolic;
  logic [pfp_pkg::VAL_W-1:0]    diastolic;

  modport source (output valid, output status, output systolic, output diastolic,
                  input ready);
  modport sink (input valid, input status, input systolic, input diastolic,
                output ready);
endinterface

`default_nettype wire

[rtl/pressure_frame_parser_unit.sv]
// Top level of the pressure frame parser: input word register, parse step
// and result register. Depends on pfp_pkg, pfp_byte_if and pfp_result_if.
//
//   channel | modport | word
//   rx      | sink    | rx_byte, one received character
//   res     | source  | status, systolic, diastolic
//
// A character is registered on acceptance and parsed once the result register
// can take a word; the result of a closing character is registered there.
// One word is accepted per cycle while the result register can drain.
// The input register holds its word only while a result waits unaccepted.
// Synchronous reset leaves the parser outside any frame with nothing pending.
`timescale 1ns / 1ps
`default_nettype none

module pressure_frame_parser_unit (
  input  wire          clk,
  input  wire          rst,
  pfp_byte_if.sink     rx,
  pfp_result_if.source res
);

  logic                       s1_valid;
  logic [pfp_pkg::BYTE_W-1:0] s1_byte;
  logic                       advance;

  logic                       in_frame, in_frame_next;
  logic [pfp_pkg::CNT_W-1:0]  char_count, char_count_next;
  logic                       field_select, field_select_next;
  pfp_pkg::phase_t            field_phase, field_phase_next;
  logic [pfp_pkg::VAL_W-1:0]  high_value, high_value_next;
  logic                       high_negative, high_negative_next;
  logic [pfp_pkg::VAL_W-1:0]  low_value, low_value_next;
  logic                       low_negative, low_negative_next;

  logic                       o_valid;
  pfp_pkg::status_t           o_status;
  logic [pfp_pkg::VAL_W-1:0]  o_systolic;
  logic [pfp_pkg::VAL_W-1:0]  o_diastolic;

  logic                       emit;
  pfp_pkg::status_t           emit_status;
  logic [pfp_pkg::VAL_W-1:0]  emit_systolic;
  logic [pfp_pkg::VAL_W-1:0]  emit_diastolic;

  logic [pfp_pkg::VAL_W-1:0]  cur_val, val_upd;
  logic                       cur_neg, neg_upd;
  pfp_pkg::phase_t            phase_upd;
  logic [pfp_pkg::ACC_W-1:0]  acc;
  logic                       hi_ok, lo_ok;

  assign advance  = s1_valid && (!o_valid || res.ready);
  assign rx.ready = !s1_valid || advance;

  assign res.valid     = o_valid;
  assign res.status    = o_status;
  assign res.systolic  = o_systolic;
  assign res.diastolic = o_diastolic;

  always_comb begin
    cur_val = field_select ? low_value : high_value;
    cur_neg = field_select ? low_negative : high_negative;
    acc = pfp_pkg::ACC_W'(cur_val) * pfp_pkg::ACC_W'(10)
        + pfp_pkg::ACC_W'(s1_byte - pfp_pkg::CH_ZERO);
    val_upd   = cur_val;
    neg_upd   = cur_neg;
    phase_upd = field_phase;
    if (field_phase == pfp_pkg::PH_SKIP && pfp_pkg::is_space(s1_byte)) begin
      phase_upd = pfp_pkg::PH_SKIP;
    end else if (field_phase == pfp_pkg::PH_SKIP &&
                 (s1_byte == pfp_pkg::CH_MINUS || s1_byte == pfp_pkg::CH_PLUS)) begin
      neg_upd   = (s1_byte == pfp_pkg::CH_MINUS);
      phase_upd = pfp_pkg::PH_DIGITS;
    end else if (field_phase != pfp_pkg::PH_DONE) begin
      if (pfp_pkg::is_digit(s1_byte)) begin
        val_upd   = (acc > pfp_pkg::ACC_W'(pfp_pkg::VAL_SAT)) ? pfp_pkg::VAL_SAT
                                                             : acc[pfp_pkg::VAL_W-1:0];
        phase_upd = pfp_pkg::PH_DIGITS;
      end else begin
        phase_upd = pfp_pkg::PH_DONE;
      end
    end
  end

  always_comb begin
    hi_ok = (high_value <= pfp_pkg::VAL_MAX) &&
            !(high_negative && high_value != '0);
    lo_ok = !low_negative && (low_value != '0) && (low_value <= pfp_pkg::VAL_MAX);
  end

  always_comb begin
    in_frame_next      = in_frame;
    char_count_next    = char_count;
    field_select_next  = field_select;
    field_phase_next   = field_phase;
    high_value_next    = high_value;
    high_negative_next = high_negative;
    low_value_next     = low_value;
    low_negative_next  = low_negative;
    emit               = 1'b0;
    emit_status        = pfp_pkg::ST_BAD;
    emit_systolic      = '0;
    emit_diastolic     = '0;
    if (s1_byte == pfp_pkg::CH_START) begin
      in_frame_next      = 1'b1;
      char_count_next    = '0;
      field_select_next  = 1'b0;
      field_phase_next   = pfp_pkg::PH_SKIP;
      high_value_next    = '0;
      high_negative_next = 1'b0;
      low_value_next     = '0;
      low_negative_next  = 1'b0;
    end else if (in_frame) begin
      if (s1_byte == pfp_pkg::CH_END) begin
        in_frame_next = 1'b0;
        emit          = 1'b1;
        if (field_select && hi_ok && lo_ok) begin
          emit_status    = pfp_pkg::ST_VALID;
          emit_systolic  = high_value;
          emit_diastolic = low_value;
        end
      end else if (char_count >= pfp_pkg::CNT_W'(pfp_pkg::MAX_PAYLOAD)) begin
        in_frame_next = 1'b0;
        emit          = 1'b1;
        emit_status   = pfp_pkg::ST_OVERFLOW;
      end else begin
        char_count_next = char_count + 1'b1;
        if (!field_select && s1_byte == pfp_pkg::CH_SEP) begin
          field_select_next = 1'b1;
          field_phase_next  = pfp_pkg::PH_SKIP;
        end else begin
          field_phase_next = phase_upd;
          if (field_select) begin
            low_value_next    = val_upd;
            low_negative_next = neg_upd;
          end else begin
            high_value_next    = val_upd;
            high_negative_next = neg_upd;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      o_valid       <= 1'b0;
      in_frame      <= 1'b0;
      char_count    <= '0;
      field_select  <= 1'b0;
      field_phase   <= pfp_pkg::PH_SKIP;
      high_value    <= '0;
      high_negative <= 1'b0;
      low_value     <= '0;
      low_negative  <= 1'b0;
    end else begin
      if (rx.valid && rx.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance && emit) begin
        o_valid <= 1'b1;
      end else if (res.ready) begin
        o_valid <= 1'b0;
      end
      if (advance) begin
        in_frame      <= in_frame_next;
        char_count    <= char_count_next;
        field_select  <= field_select_next;
        field_phase   <= field_phase_next;
        high_value    <= high_value_next;
        high_negative <= high_negative_next;
        low_value     <= low_value_next;
        low_negative  <= low_negative_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
    if (advance && emit) begin
      o_status    <= emit_status;
      o_systolic  <= emit_systolic;
      o_diastolic <= emit_diastolic;
    end
  end

endmodule

`default_nettype wire
